FILE: hdl/brmm_pkg.sv
package brmm_pkg;

    localparam int NUM_BINS    = 9;
    localparam int MAX_ITEMS   = 128;
    localparam int RATING_W    = 4;
    localparam int SUM_W       = 11;
    localparam int CNT_W       = 8;
    localparam int MEAN_W      = 12;
    localparam int MED_W       = 5;
    localparam int FRAC_W      = 8;
    localparam int BIN_IDX_W   = 4;
    localparam int DIVIDEND_W  = SUM_W + FRAC_W;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [RATING_W-1:0] RATING_MIN = RATING_W'(1);
    localparam logic [RATING_W-1:0] RATING_MAX = RATING_W'(9);
    localparam logic [CNT_W-1:0]    CNT_LIMIT  = CNT_W'(MAX_ITEMS);

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_MODE    = 1'b1;

    typedef struct packed {
        logic                ok;
        logic [RATING_W-1:0] rating;
        logic                set_end;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage

FILE: hdl/brmm_front.sv
module brmm_front
    import brmm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [RATING_W-1:0] rating,
    input  logic                set_end,
    output head_t               head,
    input  logic                pop
);

    entry_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    entry_t              in_entry;
    logic                push;
    logic                take;

    assign in_entry.ok      = (rating >= RATING_MIN) && (rating <= RATING_MAX);
    assign in_entry.rating  = rating;
    assign in_entry.set_end = set_end;

    assign in_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign take     = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.entry = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (take && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/brmm_back.sv
module brmm_back
    import brmm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  head_t               head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [SUM_W-1:0]    sum_of_ratings,
    output logic [CNT_W-1:0]    rating_count,
    output logic [MEAN_W-1:0]   mean_q8,
    output logic [MED_W-1:0]    median_doubled,
    output logic [RATING_W-1:0] mode_rating,
    output logic [CNT_W-1:0]    mode_frequency,
    output logic                input_dropped,
    output logic                final_result
);

    typedef enum logic [5:0] {
        ST_ACCUM   = 6'b000001,
        ST_CALC    = 6'b000010,
        ST_MASK    = 6'b000100,
        ST_SUMMARY = 6'b001000,
        ST_MODES   = 6'b010000,
        ST_CLEAR   = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       bins_reg [NUM_BINS];
    logic [CNT_W-1:0]       bins_next [NUM_BINS];
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       total_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [CNT_W-1:0]       cum_reg;
    logic [CNT_W-1:0]       cum_next;
    logic [CNT_W-1:0]       largest_reg;
    logic [CNT_W-1:0]       largest_next;
    logic [RATING_W-1:0]    val_a_reg;
    logic [RATING_W-1:0]    val_a_next;
    logic [RATING_W-1:0]    val_b_reg;
    logic [RATING_W-1:0]    val_b_next;
    logic [DIVIDEND_W-1:0]  dvd_reg;
    logic [DIVIDEND_W-1:0]  dvd_next;
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       rem_next;
    logic [MEAN_W-1:0]      quot_reg;
    logic [MEAN_W-1:0]      quot_next;
    logic [NUM_BINS-1:0]    mask_reg;
    logic [NUM_BINS-1:0]    mask_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   kind_reg;
    logic                   kind_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       cnt_out_reg;
    logic [CNT_W-1:0]       cnt_out_next;
    logic [MEAN_W-1:0]      mean_reg;
    logic [MEAN_W-1:0]      mean_next;
    logic [MED_W-1:0]       med_reg;
    logic [MED_W-1:0]       med_next;
    logic [RATING_W-1:0]    mr_reg;
    logic [RATING_W-1:0]    mr_next;
    logic [CNT_W-1:0]       mf_reg;
    logic [CNT_W-1:0]       mf_next;
    logic                   drop_out_reg;
    logic                   drop_out_next;
    logic                   fin_reg;
    logic                   fin_next;

    logic                   slot_free;
    logic [BIN_IDX_W-1:0]   walk_idx;
    logic [BIN_IDX_W-1:0]   upd_idx;
    logic [CNT_W-1:0]       walk_bin;
    logic [CNT_W-1:0]       walk_cum;
    logic [CNT_W-1:0]       pos_a;
    logic [CNT_W-1:0]       pos_b;
    logic [CNT_W:0]         rem_shift;
    logic [CNT_W:0]         rem_diff;
    logic [BIN_IDX_W-1:0]   pick;
    logic [NUM_BINS-1:0]    mask_rest;

    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_ACCUM);

    assign walk_idx  = step_reg[BIN_IDX_W-1:0];
    assign upd_idx   = head.entry.rating - RATING_MIN;
    assign walk_bin  = (step_reg < STEP_W'(NUM_BINS)) ? bins_reg[walk_idx] : '0;
    assign walk_cum  = cum_reg + walk_bin;
    assign pos_b     = count_reg >> 1;
    assign pos_a     = count_reg[0] ? pos_b : pos_b - 1'b1;
    assign rem_shift = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign mask_rest = mask_reg & (mask_reg - 1'b1);

    always_comb
    begin
        pick = '0;
        for (int i = NUM_BINS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = BIN_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bins_next      = bins_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        step_next      = step_reg;
        cum_next       = cum_reg;
        largest_next   = largest_reg;
        val_a_next     = val_a_reg;
        val_b_next     = val_b_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        sum_next       = sum_reg;
        cnt_out_next   = cnt_out_reg;
        mean_next      = mean_reg;
        med_next       = med_reg;
        mr_next        = mr_reg;
        mf_next        = mf_reg;
        drop_out_next  = drop_out_reg;
        fin_next       = fin_reg;

        case (state_reg)
            ST_ACCUM:
            begin
                if (head.valid)
                begin
                    if (head.entry.ok && (count_reg < CNT_LIMIT))
                    begin
                        bins_next[upd_idx] = bins_reg[upd_idx] + 1'b1;
                        total_next = total_reg + SUM_W'(head.entry.rating);
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (head.entry.set_end)
                    begin
                        step_next    = '0;
                        cum_next     = '0;
                        largest_next = '0;
                        val_a_next   = '0;
                        val_b_next   = '0;
                        state_next   = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (step_reg < STEP_W'(NUM_BINS))
                begin
                    cum_next = walk_cum;
                    if (walk_bin > largest_reg)
                    begin
                        largest_next = walk_bin;
                    end
                    if ((val_a_reg == '0) && (walk_cum > pos_a))
                    begin
                        val_a_next = walk_idx + RATING_MIN;
                    end
                    if ((val_b_reg == '0) && (walk_cum > pos_b))
                    begin
                        val_b_next = walk_idx + RATING_MIN;
                    end
                end
                if (step_reg == '0)
                begin
                    dvd_next  = {total_reg, {FRAC_W{1'b0}}};
                    rem_next  = '0;
                    quot_next = '0;
                end
                else
                begin
                    dvd_next = dvd_reg << 1;
                    if (!rem_diff[CNT_W])
                    begin
                        rem_next  = rem_diff[CNT_W-1:0];
                        quot_next = {quot_reg[MEAN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = rem_shift[CNT_W-1:0];
                        quot_next = {quot_reg[MEAN_W-2:0], 1'b0};
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVIDEND_W))
                begin
                    state_next = ST_MASK;
                end
            end
            ST_MASK:
            begin
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    mask_next[i] = (largest_reg != '0) && (bins_reg[i] == largest_reg);
                end
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SUMMARY;
                    sum_next       = total_reg;
                    cnt_out_next   = count_reg;
                    mean_next      = (count_reg == '0) ? '0 : quot_reg;
                    med_next       = MED_W'(val_a_reg) + MED_W'(val_b_reg);
                    mr_next        = '0;
                    mf_next        = largest_reg;
                    drop_out_next  = drop_reg;
                    fin_next       = (mask_reg == '0);
                    state_next     = (mask_reg == '0) ? ST_CLEAR : ST_MODES;
                end
            end
            ST_MODES:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_MODE;
                    sum_next       = '0;
                    cnt_out_next   = '0;
                    mean_next      = '0;
                    med_next       = '0;
                    mr_next        = pick + RATING_MIN;
                    mf_next        = largest_reg;
                    drop_out_next  = drop_reg;
                    fin_next       = (mask_rest == '0);
                    mask_next      = mask_rest;
                    if (mask_rest == '0)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    bins_next[i] = '0;
                end
                total_next = '0;
                count_next = '0;
                drop_next  = 1'b0;
                state_next = ST_ACCUM;
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        cum_reg      <= cum_next;
        largest_reg  <= largest_next;
        val_a_reg    <= val_a_next;
        val_b_reg    <= val_b_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        mask_reg     <= mask_next;
        kind_reg     <= kind_next;
        sum_reg      <= sum_next;
        cnt_out_reg  <= cnt_out_next;
        mean_reg     <= mean_next;
        med_reg      <= med_next;
        mr_reg       <= mr_next;
        mf_reg       <= mf_next;
        drop_out_reg <= drop_out_next;
        fin_reg      <= fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bins_reg[i] <= '0;
            end
            total_reg     <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bins_reg      <= bins_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign sum_of_ratings = sum_reg;
    assign rating_count   = cnt_out_reg;
    assign mean_q8        = mean_reg;
    assign median_doubled = med_reg;
    assign mode_rating    = mr_reg;
    assign mode_frequency = mf_reg;
    assign input_dropped  = drop_out_reg;
    assign final_result   = fin_reg;

endmodule

FILE: hdl/bounded_rating_mean_median_mode.sv
// Rating statistics: mean, median and mode of a set of ratings 1..9.
// Input channel (in_valid/in_stall): one rating per transaction, set_end on
// the last rating of a set. Ratings out of 1..9, or past 128 in one set, are
// dropped and flagged in every result of that set.
// Output channel (out_valid/out_stall): after a set ends, one summary
// transaction (kind 0) and then one per mode rating in ascending order
// (kind 1); final_result marks the last one of the set.
// Throughput: one rating per cycle while a set accumulates, through a
// four-entry queue in front of the histogram.
// After the set_end transaction, the entry passes from the queue into the
// histogram, then the bin walk runs alongside a one-bit-per-cycle divider
// for the mean, then the modes are marked and the summary is loaded into
// the result register.
// Each further result is loaded once the result register is free; then the
// histogram is cleared. The input stalls once the queue fills meanwhile.
// When the receiver stalls, the result register holds and the tail waits.
// Reset clears the histogram, totals, drop flag, queue pointers and out_valid.
module bounded_rating_mean_median_mode
    import brmm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [RATING_W-1:0] rating,
    input  logic                set_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [SUM_W-1:0]    sum_of_ratings,
    output logic [CNT_W-1:0]    rating_count,
    output logic [MEAN_W-1:0]   mean_q8,
    output logic [MED_W-1:0]    median_doubled,
    output logic [RATING_W-1:0] mode_rating,
    output logic [CNT_W-1:0]    mode_frequency,
    output logic                input_dropped,
    output logic                final_result
);

    head_t head;
    logic  pop;

    brmm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rating   (rating),
        .set_end  (set_end),
        .head     (head),
        .pop      (pop)
    );

    brmm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .sum_of_ratings (sum_of_ratings),
        .rating_count   (rating_count),
        .mean_q8        (mean_q8),
        .median_doubled (median_doubled),
        .mode_rating    (mode_rating),
        .mode_frequency (mode_frequency),
        .input_dropped  (input_dropped),
        .final_result   (final_result)
    );

endmodule
